/* rtl/pfx_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the postfix evaluator.
package pfx_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int NUM_VARS    = 26;
  localparam int VALUE_WIDTH = 32;

  localparam int STK_IW = $clog2(STACK_DEPTH);
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int VAR_IW = $clog2(NUM_VARS);
  localparam int ITER_W = $clog2(VALUE_WIDTH + 1);

  localparam int OP_W     = 3;
  localparam int LETTER_W = 5;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 40;

  // token codes
  localparam logic [OP_W-1:0] OP_SET  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH = 3'd1;
  localparam logic [OP_W-1:0] OP_ADD  = 3'd2;
  localparam logic [OP_W-1:0] OP_SUB  = 3'd3;
  localparam logic [OP_W-1:0] OP_MUL  = 3'd4;
  localparam logic [OP_W-1:0] OP_DIV  = 3'd5;
  localparam logic [OP_W-1:0] OP_POW  = 3'd6;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [1:0] ST_DIVZERO   = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RD_A,
    S_EXEC,
    S_WAIT,
    S_PUSH,
    S_FINISH,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic       load;       // capture the accepted token
    logic       var_wr;     // write value into variable table
    logic       push_var;   // push variable onto stack
    logic       note_err;   // record err_code if none recorded yet
    logic [1:0] err_code;
    logic       rd_second;  // read address is count-2 rather than count-1
    logic       latch_b;    // capture top of stack
    logic       exec;       // compute add/sub/mul, or start the iterative unit
    logic       take_unit;  // capture iterative unit result
    logic       pop_push;   // replace top two entries with result
    logic       emit;       // load the output register and clear the expression
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            last;
    logic            cnt_full;
    logic            cnt_lt2;
    logic            unit_done;
    logic            unit_dz;
    logic            out_free;
  } stat_t;

endpackage

/* rtl/postfix_expression_evaluator.sv */
// Top level of the postfix expression evaluator.
//
// Usage: tokens enter on the in_ stream, one item per token; in_tlast marks
// the final token of an expression. Only that token produces an out_ item,
// carrying the top of stack (0 when empty) and the first error of the
// expression. After it the stack and error are cleared; variables persist.
// Each token is accepted in the idle state and decoded; set, push and unused
// codes then finish. An operator reads the top, then the entry below,
// executes and replaces the top two entries with its result; divide and
// power first wait for the bit-per-cycle iterative unit, and an underflowing
// operator finishes straight after decode. A last token then loads the
// output register once it is free.
// A token is taken only when the last is done; stack reads go through one
// registered read port, so the two operands are fetched in sequence.
// Reset clears the variable table, stack count, error and output valid.
// A stalled receiver holds the result in the output register; further tokens
// are still taken, and only a following last token waits for the slot.
module postfix_expression_evaluator
  import pfx_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // op[2:0], letter[7:3], value[39:8]
  input  logic             in_tlast,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // result[31:0], status[33:32], zero pad
);

  cmd_t  cmd;
  stat_t stat;

  pfx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pfx_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* rtl/pfx_arith.sv */
// Iterative unit for truncating divide and integer power, one bit per cycle.
module pfx_arith
  import pfx_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   is_pow,
  input  logic [VALUE_WIDTH-1:0] a,
  input  logic [VALUE_WIDTH-1:0] b,
  output logic                   done,
  output logic                   div_zero,
  output logic [VALUE_WIDTH-1:0] res
);

  localparam int W = VALUE_WIDTH;
  localparam logic [W-1:0] ONE    = W'(1);
  localparam logic [W-1:0] ALL1   = {W{1'b1}};

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              pow_r;
  logic              neg_r;
  logic              dz_r;
  logic [ITER_W-1:0] iter_r;
  logic [W-1:0]      acc_r;    // remainder or running product
  logic [W-1:0]      sh_r;     // dividend/quotient or exponent
  logic [W-1:0]      opd_r;    // divisor magnitude or base

  logic [W-1:0]   mag_a, mag_b;
  logic [W:0]     trial;
  logic [W:0]     diff;
  logic [W-1:0]   prod_r, prod_b;

  assign mag_a = a[W-1] ? (~a + ONE) : a;
  assign mag_b = b[W-1] ? (~b + ONE) : b;

  // one restoring divide step
  assign trial = {acc_r, sh_r[W-1]};
  assign diff  = trial - {1'b0, opd_r};

  // square-and-multiply products, low half only
  assign prod_r = acc_r * opd_r;
  assign prod_b = opd_r * opd_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && iter_r == ITER_W'(W)) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      if (start) begin
        iter_r <= '0;
      end else if (busy_r && iter_r != ITER_W'(W)) begin
        iter_r <= iter_r + ITER_W'(1);
      end
    end
  end

  // datapath of the unit
  always_ff @(posedge clk) begin
    if (start) begin
      pow_r <= is_pow;
      neg_r <= a[W-1] ^ b[W-1];
      dz_r  <= !is_pow && (b == '0);
      if (is_pow) begin
        acc_r <= ONE;
        sh_r  <= b;
        opd_r <= a;
        // negative exponent: settle the result now and leave it
        if (b[W-1]) begin
          if (a == ONE)       acc_r <= ONE;
          else if (a == ALL1) acc_r <= b[0] ? ALL1 : ONE;
          else                acc_r <= '0;
          sh_r <= '0;
        end
      end else begin
        acc_r <= '0;
        sh_r  <= mag_a;
        opd_r <= mag_b;
      end
    end else if (busy_r && iter_r != ITER_W'(W)) begin
      if (pow_r) begin
        if (sh_r[0]) acc_r <= prod_r;
        opd_r <= prod_b;
        sh_r  <= sh_r >> 1;
      end else begin
        if (!diff[W]) begin
          acc_r <= diff[W-1:0];
          sh_r  <= {sh_r[W-2:0], 1'b1};
        end else begin
          acc_r <= trial[W-1:0];
          sh_r  <= {sh_r[W-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    if (pow_r)      res = acc_r;
    else if (dz_r)  res = '0;
    else if (neg_r) res = ~sh_r + ONE;
    else            res = sh_r;
  end

  assign done     = done_r;
  assign div_zero = dz_r && !pow_r;

endmodule

/* rtl/pfx_datapath.sv */
// Datapath: token register, operand stack memory, variable table, ALU and output register.
module pfx_datapath
  import pfx_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  input  logic [IN_W-1:0]       in_tdata,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_W-1:0]      out_tdata
);

  localparam int W = VALUE_WIDTH;

  logic [OP_W-1:0]     op_r;
  logic [LETTER_W-1:0] letter_r;
  logic [W-1:0]        value_r;
  logic                last_r;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       err_r, err_nxt;
  logic [W-1:0]     var_r [NUM_VARS];
  logic [W-1:0]     stk_mem [STACK_DEPTH];
  logic [W-1:0]     rd_data_r;
  logic [W-1:0]     b_r;
  logic [W-1:0]     res_r;
  logic             out_valid_r;
  logic [W-1:0]     out_res_r;
  logic [1:0]       out_st_r;

  logic             letter_ok;
  logic [W-1:0]     var_val;
  logic [CNT_W-1:0] rd_ptr;
  logic             wr_en;
  logic [STK_IW-1:0] wr_addr;
  logic [W-1:0]     wr_data;
  logic [W-1:0]     prod;
  logic             unit_done, unit_dz;
  logic [W-1:0]     unit_res;

  assign letter_ok = {1'b0, letter_r} < (LETTER_W+1)'(NUM_VARS);
  assign var_val   = letter_ok ? var_r[letter_r[VAR_IW-1:0]] : '0;
  assign prod      = rd_data_r * b_r;

  // capture token
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_tdata[OP_W-1:0];
      letter_r <= in_tdata[OP_W+LETTER_W-1:OP_W];
      value_r  <= in_tdata[OP_W+LETTER_W+W-1:OP_W+LETTER_W];
      last_r   <= in_tlast;
    end
  end

  // variable table, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_VARS; i++) var_r[i] <= '0;
    end else if (cmd.var_wr && letter_ok) begin
      var_r[letter_r[VAR_IW-1:0]] <= value_r;
    end
  end

  // stack memory: one write port, one registered read port
  assign rd_ptr  = cmd.rd_second ? (cnt_r - CNT_W'(2)) : (cnt_r - CNT_W'(1));
  assign wr_en   = cmd.push_var || cmd.pop_push;
  assign wr_addr = cmd.pop_push ? rd_ptr[STK_IW-1:0] : cnt_r[STK_IW-1:0];
  assign wr_data = cmd.pop_push ? res_r : var_val;

  always_ff @(posedge clk) begin
    if (wr_en) stk_mem[wr_addr] <= wr_data;
    rd_data_r <= stk_mem[rd_ptr[STK_IW-1:0]];
  end

  // operands and result
  always_ff @(posedge clk) begin
    if (cmd.latch_b) b_r <= rd_data_r;
    if (cmd.exec) begin
      case (op_r)
        OP_ADD:  res_r <= rd_data_r + b_r;
        OP_SUB:  res_r <= rd_data_r - b_r;
        default: res_r <= prod;
      endcase
    end else if (cmd.take_unit) begin
      res_r <= unit_res;
    end
  end

  pfx_arith u_arith (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.exec && (op_r == OP_DIV || op_r == OP_POW)),
    .is_pow   (op_r == OP_POW),
    .a        (rd_data_r),
    .b        (b_r),
    .done     (unit_done),
    .div_zero (unit_dz),
    .res      (unit_res)
  );

  // stack count and sticky error
  always_comb begin
    cnt_nxt = cnt_r;
    err_nxt = err_r;
    if (cmd.note_err && err_r == ST_OK) err_nxt = cmd.err_code;
    if (cmd.push_var) cnt_nxt = cnt_r + CNT_W'(1);
    if (cmd.pop_push) cnt_nxt = cnt_r - CNT_W'(1);
    if (cmd.emit) begin
      cnt_nxt = '0;
      err_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      err_r <= ST_OK;
    end else begin
      cnt_r <= cnt_nxt;
      err_r <= err_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_res_r <= (cnt_r == '0) ? '0 : rd_data_r;
      out_st_r  <= err_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_W-W-2)'(0), out_st_r, out_res_r};

  assign stat.op        = op_r;
  assign stat.last      = last_r;
  assign stat.cnt_full  = (cnt_r == CNT_W'(STACK_DEPTH));
  assign stat.cnt_lt2   = (cnt_r < CNT_W'(2));
  assign stat.unit_done = unit_done;
  assign stat.unit_dz   = unit_dz;
  assign stat.out_free  = !out_valid_r || out_tready;

endmodule

/* rtl/pfx_ctrl.sv */
// Controller state machine sequencing one token through the datapath.
module pfx_ctrl
  import pfx_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_FINISH;
        unique case (stat.op) inside
          OP_SET: cmd.var_wr = 1'b1;
          OP_PUSH: begin
            if (stat.cnt_full) begin
              cmd.note_err = 1'b1;
              cmd.err_code = ST_OVERFLOW;
            end else begin
              cmd.push_var = 1'b1;
            end
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_POW: begin
            if (stat.cnt_lt2) begin
              cmd.note_err = 1'b1;
              cmd.err_code = ST_UNDERFLOW;
            end else begin
              state_nxt = S_RD_A;
            end
          end
          default: ;
        endcase
      end
      S_RD_A: begin
        // top arrives, fetch the entry below
        cmd.latch_b   = 1'b1;
        cmd.rd_second = 1'b1;
        state_nxt     = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = (stat.op == OP_DIV || stat.op == OP_POW) ? S_WAIT : S_PUSH;
      end
      S_WAIT: begin
        if (stat.unit_done) begin
          cmd.take_unit = 1'b1;
          cmd.note_err  = stat.unit_dz;
          cmd.err_code  = ST_DIVZERO;
          state_nxt     = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.rd_second = 1'b1;
        cmd.pop_push  = 1'b1;
        state_nxt     = S_FINISH;
      end
      S_FINISH: begin
        // top-of-stack read is issued here for the result
        state_nxt = stat.last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

/* rtl/pfx_checker.sv */
// Port-level checks for the postfix expression evaluator, bound to the top level.
module pfx_checker
  import pfx_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result dropped or changed");

  // no result straight after reset
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // pad bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_W-1:VALUE_WIDTH+2] == '0)
    else $error("padding bits set");

  // a new result needs a token in flight, seen as in_tready low
  a_rise_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !in_tready || !$past(in_tready))
    else $error("result appeared without a token in flight");

endmodule

bind postfix_expression_evaluator pfx_checker u_pfx_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* tb/postfix_expression_evaluator_test.sv */
// Self-checking testbench for the postfix expression evaluator.
`timescale 1ns / 100ps

module postfix_expression_evaluator_test
  import pfx_pkg::*;
();

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [LETTER_W-1:0] letter;
    logic [31:0]         value;
    logic                last;
  } token_t;

  typedef struct packed {
    logic [31:0] result;
    logic [1:0]  status;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic in_taken = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  postfix_expression_evaluator uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #40000000;
    $display("Regression FAIL");
    $finish;
  end

  token_t  pending_tokens[$];
  answer_t awaited_answers[$];
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      hold_off_cycles = 0;
  int      error_count = 0;

  // predictor state
  logic [31:0] calc_stack[STACK_DEPTH];
  int          calc_depth = 0;
  logic [31:0] calc_vars[NUM_VARS];
  logic [1:0]  calc_err = ST_OK;

  function automatic logic [31:0] trunc_quot(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] ^ b[31]) ? -q : q;
  endfunction

  function automatic logic [31:0] int_power(logic [31:0] a, logic [31:0] b);
    logic [31:0] r, sq;
    r = 32'd1;
    sq = a;
    if (b[31]) begin
      if (a == 32'd1) return 32'd1;
      if (a == 32'hFFFF_FFFF) return b[0] ? 32'hFFFF_FFFF : 32'd1;
      return 32'd0;
    end
    for (int i = 0; i < 32; i++) begin
      if (b[i]) r = r * sq;
      sq = sq * sq;
    end
    return r;
  endfunction

  function automatic void flag_error(logic [1:0] code);
    if (calc_err == ST_OK) calc_err = code;
  endfunction

  function automatic void push_calc(logic [31:0] v);
    if (calc_depth >= STACK_DEPTH) flag_error(ST_OVERFLOW);
    else begin
      calc_stack[calc_depth] = v;
      calc_depth++;
    end
  endfunction

  // advance the predictor by one accepted token
  function automatic void evaluate_token(token_t t);
    logic [31:0] a, b, r;
    answer_t ans;
    r = '0;
    if (t.op == OP_SET) begin
      if (t.letter < NUM_VARS) calc_vars[t.letter] = t.value;
    end else if (t.op == OP_PUSH) begin
      push_calc(t.letter < NUM_VARS ? calc_vars[t.letter] : 32'd0);
    end else if (t.op <= OP_POW) begin
      if (calc_depth < 2) flag_error(ST_UNDERFLOW);
      else begin
        b = calc_stack[calc_depth-1];
        a = calc_stack[calc_depth-2];
        case (t.op)
          OP_ADD: r = a + b;
          OP_SUB: r = a - b;
          OP_MUL: r = a * b;
          OP_DIV: begin
            if (b == 0) flag_error(ST_DIVZERO);
            else r = trunc_quot(a, b);
          end
          default: r = int_power(a, b);
        endcase
        calc_depth -= 2;
        push_calc(r);
      end
    end
    if (t.last) begin
      ans.result = calc_depth ? calc_stack[calc_depth-1] : 32'd0;
      ans.status = calc_err;
      awaited_answers.push_back(ans);
      calc_depth = 0;
      calc_err = ST_OK;
    end
  endfunction

  // note each input handshake at the rising edge
  always @(posedge clk) begin
    in_taken <= rst_n && in_tvalid && in_tready;
  end

  // drive tokens at the falling edge; hold the item until accepted
  always @(negedge clk) begin
    if (in_taken) begin
      evaluate_token(pending_tokens.pop_front());
    end
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (pending_tokens.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {pending_tokens[0].value, pending_tokens[0].letter,
                      pending_tokens[0].op};
        in_tlast  <= pending_tokens[0].last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver readiness, with a counted hold-off stretch
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // check each result against the oldest expectation
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_answers.size() == 0) begin
        $error("result with none expected: %h", out_tdata);
        error_count++;
      end else begin
        want = awaited_answers.pop_front();
        if (out_tdata[31:0] !== want.result) begin
          $error("result: expected %h, got %h", want.result, out_tdata[31:0]);
          error_count++;
        end
        if (out_tdata[33:32] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tdata[33:32]);
          error_count++;
        end
      end
    end
  end

  function automatic void add_token(logic [2:0] op, logic [4:0] letter,
                                    logic [31:0] value, logic last);
    token_t t;
    t.op = op; t.letter = letter; t.value = value; t.last = last;
    pending_tokens.push_back(t);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return $urandom_range(3);
      1: return -$urandom_range(3);
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // one well-formed expression over random content, sometimes broken
  function automatic void add_random_expr();
    int depth, n;
    logic [2:0] op;
    n = $urandom_range(1, 8);
    depth = 0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0)
        add_token(OP_SET, 5'($urandom_range(31)), pick_value(), 1'b0);
      if (depth < 2 || $urandom_range(2) == 0) begin
        add_token(OP_PUSH, ($urandom_range(9) == 0) ? 5'($urandom_range(31))
                  : 5'($urandom_range(NUM_VARS - 1)), $urandom, 1'b0);
        depth++;
      end else begin
        op = 3'($urandom_range(OP_ADD, 3'd7));
        add_token(op, 5'($urandom_range(31)), $urandom, 1'b0);
        if (op != 3'd7) depth--;
      end
    end
    add_token(3'($urandom_range(7)), 5'($urandom_range(31)), $urandom, 1'b1);
  endfunction

  task automatic wait_drained();
    while (pending_tokens.size() > 0 || in_tvalid || awaited_answers.size() > 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < NUM_VARS; i++) calc_vars[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every operator and the special cases
    add_token(OP_PUSH, 5'd3, 32'd0, 1'b1);                  // reset variable
    add_token(OP_SET, 5'd0, 32'h8000_0000, 1'b0);
    add_token(OP_SET, 5'd1, 32'hFFFF_FFFF, 1'b0);
    add_token(OP_SET, 5'd25, 32'h7FFF_FFFF, 1'b0);
    add_token(OP_SET, 5'd31, 32'h1234_5678, 1'b0);          // out of range
    add_token(OP_PUSH, 5'd0, 32'd0, 1'b0);
    add_token(OP_PUSH, 5'd1, 32'd0, 1'b0);
    add_token(OP_DIV, 5'd0, 32'd0, 1'b1);                   // min / -1
    add_token(OP_PUSH, 5'd25, 32'd0, 1'b0);
    add_token(OP_PUSH, 5'd30, 32'd0, 1'b0);
    add_token(OP_DIV, 5'd0, 32'd0, 1'b0);                   // divide by zero
    add_token(OP_ADD, 5'd0, 32'd0, 1'b1);                   // then underflow
    add_token(OP_PUSH, 5'd1, 32'd0, 1'b0);
    add_token(OP_PUSH, 5'd1, 32'd0, 1'b0);
    add_token(OP_POW, 5'd0, 32'd0, 1'b1);                   // -1 ^ -1
    add_token(OP_PUSH, 5'd25, 32'd0, 1'b0);
    add_token(OP_PUSH, 5'd25, 32'd0, 1'b0);
    add_token(OP_MUL, 5'd0, 32'd0, 1'b0);
    add_token(OP_PUSH, 5'd0, 32'd0, 1'b0);
    add_token(OP_SUB, 5'd0, 32'd0, 1'b0);
    add_token(3'd7, 5'd0, 32'd0, 1'b1);                     // unused code
    for (int i = 0; i < STACK_DEPTH + 1; i++)               // overflow
      add_token(OP_PUSH, 5'd25, 32'd0, i == STACK_DEPTH);
    add_token(OP_SUB, 5'd0, 32'd0, 1'b1);                   // empty stack
    wait_drained();

    // random phases with different idling
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 49 : (phase == 3) ? 37 : 0;
      recv_stall_pct = (phase == 2) ? 49 : (phase == 3) ? 37 : 0;
      while (pending_tokens.size() < 310) add_random_expr();
      if (phase == 0) hold_off_cycles = 600;
      wait_drained();
    end

    if (error_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

/* sim.f */
rtl/pfx_pkg.sv
rtl/pfx_arith.sv
rtl/pfx_datapath.sv
rtl/pfx_ctrl.sv
rtl/postfix_expression_evaluator.sv
rtl/pfx_checker.sv
tb/postfix_expression_evaluator_test.sv
